// ----- rtl/cis_pkg.sv -----
// ---------------------------------------------------------------------------
// cis_pkg: shared types and constants for the cone isolation sums block
// Holds the default widths, the particle codes, the register map and the
// record that travels from the cone stage to the accumulators.
// ---------------------------------------------------------------------------
package cis_pkg;

	// Default sizes for the top-level parameters.
	localparam int ANGLE_BITS_DEF = 11;
	localparam int SUM_BITS_DEF   = 24;

	// Fixed field widths.
	localparam int PT_W     = 16;
	localparam int PID_W    = 12;
	localparam int RADIUS_W = 23;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;
	localparam int INDEX_W  = 1;

	// Magnitudes of the particle codes that are summed.
	localparam logic signed [PID_W-1:0] ID_CHARGED = 12'sd211;
	localparam logic signed [PID_W-1:0] ID_NEUTRAL = 12'sd130;
	localparam logic signed [PID_W-1:0] ID_PHOTON  = 12'sd22;

	// Register map, by word index.
	localparam logic [INDEX_W-1:0] REG_CONE_RADIUS_SQ = 1'b0;
	localparam logic [RADIUS_W-1:0] CONE_RADIUS_SQ_RST = 23'd9565;

	// Which sum a candidate goes into; CAT_NONE also covers "outside the cone".
	typedef enum logic [1:0] {
		CAT_NONE,
		CAT_CHARGED,
		CAT_NEUTRAL,
		CAT_PHOTON
	} cat_t;

	typedef struct packed {
		cat_t            cat;
		logic [PT_W-1:0] pt;
		logic            first;
		logic            last;
	} cand_rec_t;

endpackage

// ----- rtl/cis_apb_regs.sv -----
// ---------------------------------------------------------------------------
// cis_apb_regs: configuration register file
// Holds the cone radius squared, written and read over the APB-style port.
// ---------------------------------------------------------------------------
module cis_apb_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cis_pkg::ADDR_W-1:0]        paddr,
	input  logic [cis_pkg::DATA_W-1:0]        pwdata,
	output logic [cis_pkg::DATA_W-1:0]        prdata,
	output logic                              pready,
	output logic [cis_pkg::RADIUS_W-1:0]      cone_radius_sq
);

	logic [cis_pkg::RADIUS_W-1:0] radius_q;
	logic [cis_pkg::INDEX_W-1:0]  reg_index;
	logic                         wr_en;

	// Byte address bits below the word are ignored.
	assign reg_index = paddr[cis_pkg::ADDR_W-1:2];
	assign pready    = 1'b1;
	assign wr_en     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= cis_pkg::CONE_RADIUS_SQ_RST;
		end else if (wr_en && reg_index == cis_pkg::REG_CONE_RADIUS_SQ) begin
			radius_q <= pwdata[cis_pkg::RADIUS_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_index)
			cis_pkg::REG_CONE_RADIUS_SQ: begin
				prdata = {{(cis_pkg::DATA_W-cis_pkg::RADIUS_W){1'b0}}, radius_q};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign cone_radius_sq = radius_q;

endmodule

// ----- rtl/cis_cone_stage.sv -----
// ---------------------------------------------------------------------------
// cis_cone_stage: cone test and classification
// Forms the angular distance of one candidate, compares it with the radius
// and picks the sum it belongs to; the outcome is registered as stage 2.
// ---------------------------------------------------------------------------
module cis_cone_stage #(
	parameter int ANGLE_BITS = cis_pkg::ANGLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                load,
	input  logic signed [ANGLE_BITS-1:0]        ref_eta,
	input  logic signed [ANGLE_BITS-1:0]        ref_phi,
	input  logic signed [ANGLE_BITS-1:0]        cand_eta,
	input  logic signed [ANGLE_BITS-1:0]        cand_phi,
	input  logic [cis_pkg::PT_W-1:0]            cand_pt,
	input  logic signed [cis_pkg::PID_W-1:0]    cand_particle_id,
	input  logic                                first,
	input  logic                                last,
	input  logic [cis_pkg::RADIUS_W-1:0]        cone_radius_sq,
	output cis_pkg::cand_rec_t                  rec_s2
);

	localparam int A      = ANGLE_BITS;
	localparam int DIST_W = 2 * A + 1;
	localparam int CMP_W  = (DIST_W > cis_pkg::RADIUS_W) ? DIST_W : cis_pkg::RADIUS_W;

	logic [A:0]          deta;
	logic [A:0]          ade;
	logic [A-1:0]        dphi;
	logic [A-1:0]        adp;
	logic [2*A+1:0]      ade_sq;
	logic [2*A-1:0]      adp_sq;
	logic [DIST_W-1:0]   span_sq;
	logic [CMP_W-1:0]    dist_x;
	logic [CMP_W-1:0]    radius_x;
	logic                in_cone;
	cis_pkg::cat_t       cat;

	// The eta difference is exact; the phi difference wraps around the circle,
	// so a plain A-bit subtraction gives it.
	assign deta = {cand_eta[A-1], cand_eta} - {ref_eta[A-1], ref_eta};
	assign ade  = deta[A] ? (~deta + 1'b1) : deta;
	assign dphi = cand_phi - ref_phi;
	assign adp  = dphi[A-1] ? (~dphi + 1'b1) : dphi;

	assign ade_sq  = ade * ade;
	assign adp_sq  = adp * adp;
	assign span_sq = ade_sq[DIST_W-1:0] + {1'b0, adp_sq};

	assign dist_x   = CMP_W'(span_sq);
	assign radius_x = CMP_W'(cone_radius_sq);
	assign in_cone  = dist_x < radius_x;

	always_comb begin
		cat = cis_pkg::CAT_NONE;
		if (in_cone) begin
			if (cand_particle_id == cis_pkg::ID_CHARGED ||
			    cand_particle_id == -cis_pkg::ID_CHARGED) begin
				cat = cis_pkg::CAT_CHARGED;
			end else if (cand_particle_id == cis_pkg::ID_NEUTRAL ||
			             cand_particle_id == -cis_pkg::ID_NEUTRAL) begin
				cat = cis_pkg::CAT_NEUTRAL;
			end else if (cand_particle_id == cis_pkg::ID_PHOTON ||
			             cand_particle_id == -cis_pkg::ID_PHOTON) begin
				cat = cis_pkg::CAT_PHOTON;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_s2.cat   <= cat;
			rec_s2.pt    <= cand_pt;
			rec_s2.first <= first;
			rec_s2.last  <= last;
		end
	end

endmodule

// ----- rtl/cis_accum.sv -----
// ---------------------------------------------------------------------------
// cis_accum: saturating accumulators and result register
// Adds a classified candidate into its sum and loads the three sums into the
// result register when the candidate closes a run.
// ---------------------------------------------------------------------------
module cis_accum #(
	parameter int SUM_BITS = cis_pkg::SUM_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid_s2,
	input  cis_pkg::cand_rec_t     rec_s2,
	output logic                   go_s2,
	output logic                   sums_valid,
	input  logic                   sums_stall,
	output logic [SUM_BITS-1:0]    charged_sum,
	output logic [SUM_BITS-1:0]    neutral_sum,
	output logic [SUM_BITS-1:0]    photon_sum
);

	logic [SUM_BITS-1:0] charged_q, neutral_q, photon_q;
	logic [SUM_BITS-1:0] charged_base, neutral_base, photon_base;
	logic [SUM_BITS-1:0] charged_nx, neutral_nx, photon_nx;
	logic [SUM_BITS-1:0] add_base;
	logic [SUM_BITS:0]   add_sum;
	logic [SUM_BITS-1:0] add_sat;
	logic                out_valid_q;
	logic                out_free;
	logic                commit;

	// A beat that does not close a run never needs the result register.
	assign out_free = !out_valid_q || !sums_stall;
	assign go_s2    = !rec_s2.last || out_free;
	assign commit   = valid_s2 && go_s2;

	assign charged_base = rec_s2.first ? '0 : charged_q;
	assign neutral_base = rec_s2.first ? '0 : neutral_q;
	assign photon_base  = rec_s2.first ? '0 : photon_q;

	always_comb begin
		case (rec_s2.cat)
			cis_pkg::CAT_CHARGED: add_base = charged_base;
			cis_pkg::CAT_NEUTRAL: add_base = neutral_base;
			default:              add_base = photon_base;
		endcase
	end

	// At most one sum takes an addition per beat, so one saturating adder serves all three.
	assign add_sum = {1'b0, add_base} + (SUM_BITS+1)'(rec_s2.pt);
	assign add_sat = add_sum[SUM_BITS] ? '1 : add_sum[SUM_BITS-1:0];

	assign charged_nx = (rec_s2.cat == cis_pkg::CAT_CHARGED) ? add_sat : charged_base;
	assign neutral_nx = (rec_s2.cat == cis_pkg::CAT_NEUTRAL) ? add_sat : neutral_base;
	assign photon_nx  = (rec_s2.cat == cis_pkg::CAT_PHOTON)  ? add_sat : photon_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charged_q <= '0;
			neutral_q <= '0;
			photon_q  <= '0;
		end else if (commit) begin
			charged_q <= charged_nx;
			neutral_q <= neutral_nx;
			photon_q  <= photon_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit && rec_s2.last) begin
			out_valid_q <= 1'b1;
		end else if (!sums_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && rec_s2.last) begin
			charged_sum <= charged_nx;
			neutral_sum <= neutral_nx;
			photon_sum  <= photon_nx;
		end
	end

	assign sums_valid = out_valid_q;

endmodule

// ----- rtl/cone_isolation_sums.sv -----
// ---------------------------------------------------------------------------
// cone_isolation_sums: particle-flow cone isolation sums
// Streams particle candidates against a reference direction and keeps
// separate saturating pt sums of charged hadrons, neutral hadrons and photons
// that fall inside a configurable cone.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake              Direction  Beat contents
//  cand      cand_valid/cand_stall  in         ref and cand angles, pt, id,
//                                              first, last
//  sums      sums_valid/sums_stall  out        charged, neutral, photon sums
//  config    psel/penable/pwrite    in         cone_radius_sq at byte addr 0
//
//  Cycles: one candidate beat per clock unless a closing beat waits for the
//  result register. A candidate passes the input and cone stage registers,
//  and a run's sums load into the result register as its last beat commits;
//  the accumulator feedback loop through the sum registers sets the rate.
//  Reset: arst_n clears all valid flags and the three sums and loads the
//  default radius of 9565 (about 0.3 squared); no clearing pass is needed.
//  Stalls: only a beat that closes a run waits for the result register, so
//  candidates keep flowing while a finished result sits unclaimed until such
//  a beat reaches the accumulators.
//
module cone_isolation_sums #(
	parameter int ANGLE_BITS = cis_pkg::ANGLE_BITS_DEF,
	parameter int SUM_BITS   = cis_pkg::SUM_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	// Candidate beats.
	input  logic                                cand_valid,
	output logic                                cand_stall,
	input  logic signed [ANGLE_BITS-1:0]        ref_eta,
	input  logic signed [ANGLE_BITS-1:0]        ref_phi,
	input  logic signed [ANGLE_BITS-1:0]        cand_eta,
	input  logic signed [ANGLE_BITS-1:0]        cand_phi,
	input  logic [cis_pkg::PT_W-1:0]            cand_pt,
	input  logic signed [cis_pkg::PID_W-1:0]    cand_particle_id,
	input  logic                                first,
	input  logic                                last,

	// Result beats.
	output logic                                sums_valid,
	input  logic                                sums_stall,
	output logic [SUM_BITS-1:0]                 charged_sum,
	output logic [SUM_BITS-1:0]                 neutral_sum,
	output logic [SUM_BITS-1:0]                 photon_sum,

	// Configuration port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cis_pkg::ADDR_W-1:0]          paddr,
	input  logic [cis_pkg::DATA_W-1:0]          pwdata,
	output logic [cis_pkg::DATA_W-1:0]          prdata,
	output logic                                pready
);

	// Input register, stage 1.
	logic                              valid_s1;
	logic signed [ANGLE_BITS-1:0]      ref_eta_s1, ref_phi_s1;
	logic signed [ANGLE_BITS-1:0]      cand_eta_s1, cand_phi_s1;
	logic [cis_pkg::PT_W-1:0]          cand_pt_s1;
	logic signed [cis_pkg::PID_W-1:0]  cand_pid_s1;
	logic                              first_s1, last_s1;

	// Cone stage register, stage 2.
	logic                              valid_s2;
	cis_pkg::cand_rec_t                rec_s2;

	logic                              go_s2;
	logic                              load_s2;
	logic                              load_s1;
	logic [cis_pkg::RADIUS_W-1:0]      cone_radius_sq;

	// Each stage takes a new beat when it is empty or its beat moves on.
	assign load_s2    = !valid_s2 || go_s2;
	assign load_s1    = !valid_s1 || load_s2;
	assign cand_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= cand_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			ref_eta_s1  <= ref_eta;
			ref_phi_s1  <= ref_phi;
			cand_eta_s1 <= cand_eta;
			cand_phi_s1 <= cand_phi;
			cand_pt_s1  <= cand_pt;
			cand_pid_s1 <= cand_particle_id;
			first_s1    <= first;
			last_s1     <= last;
		end
	end

	cis_apb_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.cone_radius_sq (cone_radius_sq)
	);

	// Distance, cone test and category; registered into stage 2.
	cis_cone_stage #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_cone (
		.clk              (clk),
		.load             (load_s2),
		.ref_eta          (ref_eta_s1),
		.ref_phi          (ref_phi_s1),
		.cand_eta         (cand_eta_s1),
		.cand_phi         (cand_phi_s1),
		.cand_pt          (cand_pt_s1),
		.cand_particle_id (cand_pid_s1),
		.first            (first_s1),
		.last             (last_s1),
		.cone_radius_sq   (cone_radius_sq),
		.rec_s2           (rec_s2)
	);

	// Sums and the result register.
	cis_accum #(
		.SUM_BITS (SUM_BITS)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s2    (valid_s2),
		.rec_s2      (rec_s2),
		.go_s2       (go_s2),
		.sums_valid  (sums_valid),
		.sums_stall  (sums_stall),
		.charged_sum (charged_sum),
		.neutral_sum (neutral_sum),
		.photon_sum  (photon_sum)
	);

endmodule
